FILE: rtl/core/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
package spq_pkg;

  localparam logic [1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [1:0] CMD_PEEK    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] payload;
    logic [7:0]  priority_req;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_out;
    logic [3:0]  entry_count;
  } spq_out_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } spq_ctrl_t;

endpackage

FILE: rtl/core/sorted_priority_queue.sv
// Sorted priority queue, top level: controller plus entry datapath.
// Each command (enqueue, dequeue, peek) is captured on the edge where start
// is high and busy is low, and the whole entry row is updated in parallel on
// the next edge; for an enqueue every cell compares its priority against the
// new one. The result is shown for exactly one cycle with out_valid high,
// rising on the edge at which busy falls, and the receiver cannot stall it;
// a new start may be given in that same cycle. Entries of equal priority
// leave in arrival order. Stored entries are not cleared by reset; only the
// entry count is.
module sorted_priority_queue #(
  parameter int CAPACITY      = 8,
  parameter int PAYLOAD_BITS  = 32,
  parameter int PRIORITY_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::spq_in_t  in_data,
  output logic              out_valid,
  output spq_pkg::spq_out_t out_data
);
  import spq_pkg::*;

  spq_ctrl_t ctrl;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  spq_dpath #(
    .CAPACITY      (CAPACITY),
    .PAYLOAD_BITS  (PAYLOAD_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

FILE: rtl/core/spq_ctrl.sv
// Controller state machine: sequences capture and execute of one command.
module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output spq_pkg::spq_ctrl_t ctrl
);
  import spq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   busy_r;
  logic   out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          out_valid_r <= 1'b0;
          if (start) begin
            state_r <= S_EXEC;
            busy_r  <= 1'b1;
          end
        end
        S_EXEC: begin
          state_r     <= S_IDLE;
          busy_r      <= 1'b0;
          out_valid_r <= 1'b1;
        end
        default: begin
          state_r     <= S_IDLE;
          busy_r      <= 1'b0;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign busy         = busy_r;
  assign out_valid    = out_valid_r;
  assign ctrl.capture = (state_r == S_IDLE) && start;
  assign ctrl.execute = (state_r == S_EXEC);

endmodule

FILE: rtl/core/spq_dpath.sv
// Datapath: sorted row of entry cells, entry count and result register.
module spq_dpath #(
  parameter int CAPACITY      = 8,
  parameter int PAYLOAD_BITS  = 32,
  parameter int PRIORITY_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::spq_ctrl_t ctrl,
  input  spq_pkg::spq_in_t   in_data,
  output spq_pkg::spq_out_t  out_data
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [1:0]               cmd_r;
  logic [PAYLOAD_BITS-1:0]  pay_r;
  logic [PRIORITY_BITS-1:0] pri_r;

  logic [PAYLOAD_BITS-1:0]  cell_pay_r [CAPACITY];
  logic [PRIORITY_BITS-1:0] cell_pri_r [CAPACITY];
  logic [PAYLOAD_BITS-1:0]  cell_pay_nxt [CAPACITY];
  logic [PRIORITY_BITS-1:0] cell_pri_nxt [CAPACITY];
  logic [CAPACITY-1:0]      ge;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [1:0]       status_nxt;
  logic [PAYLOAD_BITS-1:0] data_nxt;
  logic             full;
  logic             empty;

  logic [1:0]       status_r;
  logic [31:0]      data_out_r;
  logic [3:0]       count_out_r;

  logic [63:0] pay_wide;
  logic [63:0] pri_wide;
  logic [63:0] data_wide;
  logic [15:0] count_wide;

  // Input fields are zero-extended, then cut to the stored widths.
  assign pay_wide = {32'd0, in_data.payload};
  assign pri_wide = {56'd0, in_data.priority_req};

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r <= in_data.command;
      pay_r <= pay_wide[PAYLOAD_BITS-1:0];
      pri_r <= pri_wide[PRIORITY_BITS-1:0];
    end
  end

  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  // Cells at or ahead of a valid entry with equal or higher priority stay;
  // the list is sorted, so these cells form a prefix.
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      ge[k] = (CNT_W'(k) < count_r) && (cell_pri_r[k] >= pri_r);
    end
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    data_nxt   = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      cell_pay_nxt[k] = cell_pay_r[k];
      cell_pri_nxt[k] = cell_pri_r[k];
    end
    unique case (cmd_r)
      CMD_ENQUEUE: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          for (int k = 0; k < CAPACITY; k++) begin
            if (!ge[k]) begin
              if (k == 0 || ge[(k == 0) ? 0 : k - 1]) begin
                cell_pay_nxt[k] = pay_r;
                cell_pri_nxt[k] = pri_r;
              end else begin
                cell_pay_nxt[k] = cell_pay_r[(k == 0) ? 0 : k - 1];
                cell_pri_nxt[k] = cell_pri_r[(k == 0) ? 0 : k - 1];
              end
            end
          end
        end
      end
      CMD_DEQUEUE, CMD_PEEK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          data_nxt = cell_pay_r[0];
          if (cmd_r == CMD_DEQUEUE) begin
            count_nxt = count_r - CNT_W'(1);
            for (int k = 0; k < CAPACITY - 1; k++) begin
              cell_pay_nxt[k] = cell_pay_r[k + 1];
              cell_pri_nxt[k] = cell_pri_r[k + 1];
            end
          end
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  assign data_wide  = 64'(data_nxt);
  assign count_wide = 16'(count_nxt);

  always_ff @(posedge clk) begin
    if (ctrl.execute) begin
      for (int k = 0; k < CAPACITY; k++) begin
        cell_pay_r[k] <= cell_pay_nxt[k];
        cell_pri_r[k] <= cell_pri_nxt[k];
      end
      status_r    <= status_nxt;
      data_out_r  <= data_wide[31:0];
      count_out_r <= count_wide[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.execute) begin
      count_r <= count_nxt;
    end
  end

  assign out_data.status      = status_r;
  assign out_data.data_out    = data_out_r;
  assign out_data.entry_count = count_out_r;

endmodule

FILE: rtl/core/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_checker #(
  parameter int CAPACITY = 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input spq_pkg::spq_out_t out_data
);
  import spq_pkg::*;

  localparam logic [3:0] CAP_CODE = 4'(CAPACITY);

  // Every accepted command gives its result once its execute state has passed.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted command produced no result");

  // A result transfer is always preceded by a busy cycle.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a preceding busy cycle");

  // A full refusal reports the queue at capacity.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_FULL) |-> (out_data.entry_count == CAP_CODE))
    else $error("full status with a count below capacity");

  // An empty status reports no entries and no data.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_EMPTY)
      |-> (out_data.entry_count == 4'd0 && out_data.data_out == 32'd0))
    else $error("empty status with entries or data");

endmodule

bind sorted_priority_queue spq_checker #(
  .CAPACITY (CAPACITY)
) u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

FILE: bench/tb_sorted_priority_queue.sv
// Self-checking testbench for the sorted priority queue: directed and random command traffic.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = 8;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int MAX_GAP = 18;
  localparam int RANDOM_COMMANDS = 700;

  class spq_scoreboard;
    logic [31:0] slot_payload [QUEUE_DEPTH];
    logic [7:0]  slot_priority [QUEUE_DEPTH];
    int unsigned slot_count = 0;
    spq_out_t    awaited_results [$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned full_refusals = 0;
    int unsigned empty_replies = 0;
    int unsigned command_tally [4] = '{0, 0, 0, 0};

    // Updates the queue image for one accepted command and records its outcome.
    function void note_command(spq_in_t cmd);
      spq_out_t outcome;
      int unsigned pos;
      int unsigned k;
      outcome = '0;
      outcome.status = ST_OK;
      command_tally[cmd.command]++;
      case (cmd.command)
        CMD_ENQUEUE: begin
          if (slot_count >= QUEUE_DEPTH) begin
            outcome.status = ST_FULL;
            full_refusals++;
          end else begin
            // New entry goes behind every entry of equal or higher priority.
            pos = 0;
            while (pos < slot_count && slot_priority[pos] >= cmd.priority_req) pos++;
            for (k = slot_count; k > pos; k--) begin
              slot_payload[k]  = slot_payload[k - 1];
              slot_priority[k] = slot_priority[k - 1];
            end
            slot_payload[pos]  = cmd.payload;
            slot_priority[pos] = cmd.priority_req;
            slot_count++;
          end
        end
        CMD_DEQUEUE, CMD_PEEK: begin
          if (slot_count == 0) begin
            outcome.status = ST_EMPTY;
            empty_replies++;
          end else begin
            outcome.data_out = slot_payload[0];
            if (cmd.command == CMD_DEQUEUE) begin
              for (k = 1; k < slot_count; k++) begin
                slot_payload[k - 1]  = slot_payload[k];
                slot_priority[k - 1] = slot_priority[k];
              end
              slot_count--;
            end
          end
        end
        default: ;
      endcase
      outcome.entry_count = 4'(slot_count);
      awaited_results.push_back(outcome);
    endfunction

    function void report_failure(string what, spq_out_t want, spq_out_t got);
      string head;
      mismatches++;
      if (mismatches <= 10) begin
        head = $sformatf("%0t ns: %s: expected status=%0d data=%08h count=%0d,",
                         $time, what, want.status, want.data_out, want.entry_count);
        $display("%s got status=%0d data=%08h count=%0d",
                 head, got.status, got.data_out, got.entry_count);
      end
    endfunction

    function void check_result(spq_out_t got);
      spq_out_t want;
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_failure("result with no command outstanding", '0, got);
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status || got.data_out !== want.data_out ||
          got.entry_count !== want.entry_count)
        report_failure("result mismatch", want, got);
    endfunction

    function void flush_missing();
      while (awaited_results.size() > 0)
        report_failure("result never arrived", awaited_results.pop_front(), 'x);
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  spq_in_t  in_data = '0;
  logic     out_valid;
  spq_out_t out_data;

  spq_scoreboard sb;

  sorted_priority_queue DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) sb.check_result(out_data);
  end

  function automatic spq_in_t make_command(logic [1:0] op, logic [31:0] tag, logic [7:0] prio);
    spq_in_t cmd;
    cmd.command      = op;
    cmd.payload      = tag;
    cmd.priority_req = prio;
    return cmd;
  endfunction

  // Holds start low for the idle gap given by gap, then presents the command
  // until the transfer completes on an edge where busy is low.
  task automatic send_command(input spq_in_t cmd, input int unsigned gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_command(cmd);
  endtask

  task automatic send_directed(input logic [1:0] op, input logic [31:0] tag,
                               input logic [7:0] prio);
    send_command(make_command(op, tag, prio), $urandom_range(0, 3) == 0 ? 0 :
                 $urandom_range(0, MAX_GAP));
  endtask

  task automatic run_random_traffic();
    int unsigned issued;
    int unsigned seg_len;
    int unsigned flavor;
    int unsigned prio_style;
    bit          idle_on;
    int unsigned roll;
    logic [1:0]  op;
    logic [7:0]  prio;
    issued = 0;
    while (issued < RANDOM_COMMANDS) begin
      // Each stretch leans toward filling, draining, mixing or ties.
      flavor     = $urandom_range(0, 3);
      prio_style = $urandom_range(0, 2);
      idle_on    = ($urandom_range(0, 2) != 0);
      seg_len    = $urandom_range(8, 30);
      repeat (seg_len) begin
        roll = $urandom_range(0, 99);
        case (flavor)
          0:       op = roll < 75 ? CMD_ENQUEUE : (roll < 90 ? CMD_DEQUEUE : CMD_PEEK);
          1:       op = roll < 15 ? CMD_ENQUEUE : (roll < 80 ? CMD_DEQUEUE : CMD_PEEK);
          default: op = roll < 45 ? CMD_ENQUEUE : (roll < 80 ? CMD_DEQUEUE : CMD_PEEK);
        endcase
        if ($urandom_range(0, 49) == 0) op = CMD_UNUSED;
        case (prio_style)
          0:       prio = 8'($urandom_range(0, 255));
          1:       prio = 8'($urandom_range(0, 3)) * 8'd85;
          default: prio = flavor == 3 ? 8'($urandom_range(6, 7)) : 8'($urandom_range(0, 15));
        endcase
        send_command(make_command(op, $urandom, prio),
                     idle_on ? $urandom_range(0, MAX_GAP) : 0);
        issued++;
      end
    end
  endtask

  initial begin
    int unsigned waited;
    sb = new();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Empty-queue replies and the unused code on an empty queue.
    send_directed(CMD_DEQUEUE, 32'hDEAD_BEEF, 8'd9);
    send_directed(CMD_PEEK, 32'h1234_5678, 8'd200);
    send_directed(CMD_UNUSED, 32'hFFFF_FFFF, 8'hFF);
    // Fill to capacity with extremes and ties, then overflow.
    send_directed(CMD_ENQUEUE, 32'h0000_0000, 8'd0);
    send_directed(CMD_ENQUEUE, 32'hFFFF_FFFF, 8'd255);
    send_directed(CMD_ENQUEUE, 32'h0000_0001, 8'd255);
    send_directed(CMD_ENQUEUE, 32'hA5A5_A5A5, 8'd100);
    send_directed(CMD_ENQUEUE, 32'h5A5A_5A5A, 8'd100);
    send_directed(CMD_ENQUEUE, 32'h0000_0007, 8'd7);
    send_directed(CMD_ENQUEUE, 32'h8000_0000, 8'd200);
    send_directed(CMD_ENQUEUE, 32'h7FFF_FFFF, 8'd128);
    send_directed(CMD_ENQUEUE, 32'hCAFE_F00D, 8'd255);
    send_directed(CMD_UNUSED, 32'h0, 8'd0);
    send_directed(CMD_PEEK, 32'h0, 8'd0);
    repeat (QUEUE_DEPTH) send_directed(CMD_DEQUEUE, 32'h0, 8'd0);
    send_directed(CMD_DEQUEUE, 32'h0, 8'd0);

    run_random_traffic();
    @(negedge clk);
    start <= 1'b0;

    waited = 0;
    while (sb.awaited_results.size() > 0 && waited < 100) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    sb.flush_missing();

    $display(
      "Ran %0d enqueues, %0d dequeues, %0d peeks and %0d unused codes; %0d results checked.",
      sb.command_tally[CMD_ENQUEUE], sb.command_tally[CMD_DEQUEUE],
      sb.command_tally[CMD_PEEK], sb.command_tally[CMD_UNUSED], sb.results_seen);
    $display("Saw %0d refusals on a full queue and %0d replies on an empty one; %0d failures.",
             sb.full_refusals, sb.empty_replies, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("sorted_priority_queue test passed");
    end else begin
      $display("sorted_priority_queue test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("sorted_priority_queue test failed");
    $finish;
  end

endmodule
